// ===== sv/status_led_pattern_driver_macros.svh =====
// Assertion macros shared by the status LED pattern driver modules.
`ifndef STATUS_LED_PATTERN_DRIVER_MACROS_SVH
`define STATUS_LED_PATTERN_DRIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLDRV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLDRV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sldrv_pkg.sv =====
// Types and constants of the status LED pattern driver.
package sldrv_pkg;

    typedef enum logic [2:0] {
        PAT_OFF    = 3'd0,
        PAT_STEADY = 3'd1,
        PAT_SLOW   = 3'd2,
        PAT_FAST   = 3'd3,
        PAT_DOUBLE = 3'd4
    } sldrv_pat_t;

    // Connector status codes; everything from 7 up means unavailable.
    localparam logic [3:0] CONN_AVAILABLE      = 4'd0;
    localparam logic [3:0] CONN_PREPARING      = 4'd1;
    localparam logic [3:0] CONN_CHARGING       = 4'd2;
    localparam logic [3:0] CONN_SUSPENDED_EVSE = 4'd3;
    localparam logic [3:0] CONN_SUSPENDED_EV   = 4'd4;
    localparam logic [3:0] CONN_FINISHING      = 4'd5;
    localparam logic [3:0] CONN_FAULTED        = 4'd6;

    localparam int TIME_W = 32;
    localparam int QUO_W  = 11;  // quotient bits kept: only the low ones matter
    localparam int RAW_W  = 11;  // raw remainder, below twice the period
    localparam int REM_W  = 10;  // remainder modulo the period

    // floor(2^32 / 1000): quotient estimate is exact or one low
    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 23'd4294967;

    localparam logic [RAW_W-1:0] PERIOD_MS   = 11'd1000;
    localparam logic [REM_W-1:0] HALF_MS     = 10'd500;
    localparam logic [REM_W-1:0] FAST_ON_MS  = 10'd250;
    localparam logic [REM_W-1:0] PULSE_MS    = 10'd150;
    localparam logic [REM_W-1:0] PULSE2_ON   = 10'd300;
    localparam logic [REM_W-1:0] PULSE2_OFF  = 10'd450;

    typedef struct packed {
        logic s2_load;
        logic s3_load;
        logic s4_load;
        logic out_load;
    } sldrv_adv_t;

endpackage

// ===== sv/sldrv_select.sv =====
// Priority selection of the blink pattern for each of the three LEDs.
module sldrv_select
    import sldrv_pkg::*;
(
    input  logic       ocpp_ready,
    input  logic       fault_locked,
    input  logic       network_up,
    input  logic       socket_up,
    input  logic [3:0] connector_status,
    output sldrv_pat_t chg_pat,
    output sldrv_pat_t nwk_pat,
    output sldrv_pat_t flt_pat
);

    logic fault;
    logic sock;

    // Ignore socket and connector until the protocol stack is ready
    assign sock  = ocpp_ready && socket_up;
    assign fault = fault_locked || (ocpp_ready && (connector_status == CONN_FAULTED));

    always_comb
    begin
        if (fault)
        begin
            chg_pat = PAT_OFF;
        end
        else if (!ocpp_ready)
        begin
            chg_pat = PAT_FAST;
        end
        else
        begin
            case (connector_status)
                CONN_AVAILABLE:      chg_pat = PAT_STEADY;
                CONN_PREPARING:      chg_pat = PAT_DOUBLE;
                CONN_FINISHING:      chg_pat = PAT_DOUBLE;
                CONN_CHARGING:       chg_pat = PAT_SLOW;
                CONN_SUSPENDED_EVSE: chg_pat = PAT_FAST;
                CONN_SUSPENDED_EV:   chg_pat = PAT_FAST;
                CONN_FAULTED:        chg_pat = PAT_OFF;
                default:             chg_pat = PAT_STEADY;
            endcase
        end
    end

    always_comb
    begin
        if (!network_up)
        begin
            nwk_pat = PAT_STEADY;
        end
        else if (!ocpp_ready || !sock)
        begin
            nwk_pat = PAT_FAST;
        end
        else
        begin
            nwk_pat = PAT_SLOW;
        end
    end

    assign flt_pat = fault ? PAT_FAST : PAT_OFF;

endmodule

// ===== sv/sldrv_lane.sv =====
// One LED lane: pattern and phase state, elapsed-time remainder pipeline, level.
`include "status_led_pattern_driver_macros.svh"

module sldrv_lane
    import sldrv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sldrv_adv_t        adv,
    input  sldrv_pat_t        pat_in,
    input  logic [TIME_W-1:0] now_in,
    output logic              level
);

    sldrv_pat_t              prior_pattern_reg, prior_pattern_next;
    logic [TIME_W-1:0]       phase_origin_reg, phase_origin_next;

    sldrv_pat_t              s2_pat_reg, s3_pat_reg, s4_pat_reg;
    logic [TIME_W-1:0]       e_reg, e_next;
    logic [QUO_W-1:0]        q_reg;
    logic [RAW_W-1:0]        e_lo_reg;
    logic [RAW_W-1:0]        raw_reg, raw_next;

    logic [TIME_W+RECIP_W-1:0] recip_mul;
    logic [QUO_W+RAW_W-1:0]    qm;
    logic [RAW_W-1:0]          t_wide;
    logic [REM_W-1:0]          t;
    logic [REM_W-1:0]          h;

    // Restart the phase on a pattern change
    always_comb
    begin
        prior_pattern_next = prior_pattern_reg;
        phase_origin_next  = phase_origin_reg;
        e_next             = now_in - phase_origin_reg;
        if (pat_in != prior_pattern_reg)
        begin
            prior_pattern_next = pat_in;
            phase_origin_next  = now_in;
            e_next             = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_pattern_reg <= PAT_OFF;
            phase_origin_reg  <= '0;
        end
        else if (adv.s2_load)
        begin
            prior_pattern_reg <= prior_pattern_next;
            phase_origin_reg  <= phase_origin_next;
        end
    end

    // Quotient estimate by reciprocal, then raw remainder, then correction
    assign recip_mul = (TIME_W+RECIP_W)'(e_reg) * (TIME_W+RECIP_W)'(RECIP_1000);
    assign qm        = (QUO_W+RAW_W)'(q_reg) * (QUO_W+RAW_W)'(PERIOD_MS);
    assign raw_next  = e_lo_reg - qm[RAW_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv.s2_load)
        begin
            s2_pat_reg <= pat_in;
            e_reg      <= e_next;
        end
        if (adv.s3_load)
        begin
            s3_pat_reg <= s2_pat_reg;
            q_reg      <= recip_mul[TIME_W+QUO_W-1:TIME_W];
            e_lo_reg   <= e_reg[RAW_W-1:0];
        end
        if (adv.s4_load)
        begin
            s4_pat_reg <= s3_pat_reg;
            raw_reg    <= raw_next;
        end
    end

    assign t_wide = (raw_reg >= PERIOD_MS) ? (raw_reg - PERIOD_MS) : raw_reg;
    assign t      = t_wide[REM_W-1:0];
    assign h      = (t >= HALF_MS) ? (t - HALF_MS) : t;

    always_comb
    begin
        case (s4_pat_reg)
            PAT_STEADY: level = 1'b1;
            PAT_SLOW:   level = (t < HALF_MS);
            PAT_FAST:   level = (h < FAST_ON_MS);
            PAT_DOUBLE: level = (t < PULSE_MS) || ((t >= PULSE2_ON) && (t < PULSE2_OFF));
            default:    level = 1'b0;
        endcase
    end

    `SLDRV_ASSERT_NEXT(a_restart_zero, adv.s2_load && (pat_in != prior_pattern_reg), e_reg == '0, "phase restart did not clear elapsed time")
    `SLDRV_ASSERT_NEXT(a_state_hold, !adv.s2_load, $stable(phase_origin_reg) && $stable(prior_pattern_reg), "lane state moved without a transfer")
    `SLDRV_ASSERT_IMPL(a_raw_range, adv.out_load, raw_reg < (PERIOD_MS + PERIOD_MS), "raw remainder out of range")

endmodule

// ===== sv/status_led_pattern_driver.sv =====
// Top level of the status LED pattern driver: input register, pipeline control, result register.
// Each transfer on the input channel is one poll tick: a millisecond time stamp plus the charger
// status flags. A fixed priority picks a pattern for the charger, network and fault LEDs (off,
// steady, slow blink 500/1000 ms, fast blink 250/500 ms, double pulse of two 150 ms flashes per
// 1000 ms). Each LED restarts its phase when its pattern changes, and its level comes from the
// time since that restart, modulo 2^32. One item is taken every clock cycle unless in_stall is
// high, which happens only when every stage is full and the output is stalled. Each item passes
// through the remainder pipeline: the pattern and phase update, a reciprocal multiply for the
// quotient by 1000, the raw remainder, and the correction with the level decode. Results leave
// in input order; a stalled result does not hold up the stages behind it until the pipe is full.
`include "status_led_pattern_driver_macros.svh"

module status_led_pattern_driver
    import sldrv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              ocpp_ready,
    input  logic              fault_locked,
    input  logic              network_up,
    input  logic              socket_up,
    input  logic [3:0]        connector_status,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              charger_led,
    output logic              network_led,
    output logic              fault_led
);

    // Stage valids; each stage moves when the next one is empty or moving
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic out_valid_reg, out_valid_next;

    logic ready1, ready2, ready3, ready4, out_ready;
    logic in_load;
    sldrv_adv_t adv;

    // Input register
    logic [TIME_W-1:0] now_reg;
    logic              ready_reg, fault_reg, net_reg, sock_reg;
    logic [3:0]        status_reg;

    sldrv_pat_t chg_pat, nwk_pat, flt_pat;
    logic       chg_level, nwk_level, flt_level;

    logic charger_led_reg, network_led_reg, fault_led_reg;

    assign out_ready    = !out_valid_reg || !out_stall;
    assign ready4       = !s4_valid_reg || out_ready;
    assign ready3       = !s3_valid_reg || ready4;
    assign ready2       = !s2_valid_reg || ready3;
    assign ready1       = !s1_valid_reg || ready2;

    assign in_load      = in_valid && ready1;
    assign adv.s2_load  = s1_valid_reg && ready2;
    assign adv.s3_load  = s2_valid_reg && ready3;
    assign adv.s4_load  = s3_valid_reg && ready4;
    assign adv.out_load = s4_valid_reg && out_ready;

    assign in_stall     = !ready1;

    // Set a stage on load into it, drop it when it drains, else hold
    assign s1_valid_next  = in_load     ? 1'b1 : (adv.s2_load  ? 1'b0 : s1_valid_reg);
    assign s2_valid_next  = adv.s2_load ? 1'b1 : (adv.s3_load  ? 1'b0 : s2_valid_reg);
    assign s3_valid_next  = adv.s3_load ? 1'b1 : (adv.s4_load  ? 1'b0 : s3_valid_reg);
    assign s4_valid_next  = adv.s4_load ? 1'b1 : (adv.out_load ? 1'b0 : s4_valid_reg);
    assign out_valid_next = adv.out_load ? 1'b1 : (!out_stall  ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the poll tick on transfer
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            now_reg    <= now_ms;
            ready_reg  <= ocpp_ready;
            fault_reg  <= fault_locked;
            net_reg    <= network_up;
            sock_reg   <= socket_up;
            status_reg <= connector_status;
        end
    end

    sldrv_select u_select (
        .ocpp_ready       (ready_reg),
        .fault_locked     (fault_reg),
        .network_up       (net_reg),
        .socket_up        (sock_reg),
        .connector_status (status_reg),
        .chg_pat          (chg_pat),
        .nwk_pat          (nwk_pat),
        .flt_pat          (flt_pat)
    );

    sldrv_lane u_lane_chg (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .pat_in (chg_pat),
        .now_in (now_reg),
        .level  (chg_level)
    );

    sldrv_lane u_lane_nwk (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .pat_in (nwk_pat),
        .now_in (now_reg),
        .level  (nwk_level)
    );

    sldrv_lane u_lane_flt (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .pat_in (flt_pat),
        .now_in (now_reg),
        .level  (flt_level)
    );

    // Result register: hold while stalled
    always_ff @(posedge clk)
    begin
        if (adv.out_load)
        begin
            charger_led_reg <= chg_level;
            network_led_reg <= nwk_level;
            fault_led_reg   <= flt_level;
        end
    end

    assign out_valid   = out_valid_reg;
    assign charger_led = charger_led_reg;
    assign network_led = network_led_reg;
    assign fault_led   = fault_led_reg;

    `SLDRV_ASSERT_IMPL(a_stall_only_full, in_stall, s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && out_valid_reg, "input stalled with room in the pipe")
    `SLDRV_ASSERT_NEXT(a_out_fill, s4_valid_reg && !out_valid_reg, out_valid_reg, "last stage did not drain into an empty result register")
    `SLDRV_ASSERT_NEXT(a_s2_fill, s1_valid_reg && !s2_valid_reg, s2_valid_reg, "input register did not advance into an empty stage")

endmodule
